### rtl/assert_macros.svh
// Assertion macros shared by the RTL of the YUYV to BGR converter.
// Each macro expects signals named clk and rst_n in the including scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge outside reset.
`define YTB_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication checked at every rising edge outside reset.
`define YTB_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

### rtl/ytb_pkg.sv
// Package for the YUYV to BGR converter: fixed-point coefficients and widths,
// and the channel clamp function. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ytb_pkg;

    localparam int CFG_W   = 11;
    localparam int CFG_MAX = 2 ** CFG_W - 1;
    localparam int ADDR_W  = 20;
    localparam int SUM_W   = 26;
    localparam int FRAC_W  = 14;

    localparam logic signed [15:0] COEF_RV = 16'sd22970;
    localparam logic signed [15:0] COEF_GU = 16'sd5638;
    localparam logic signed [15:0] COEF_GV = 16'sd11700;
    localparam logic signed [15:0] COEF_BU = 16'sd29032;

    localparam logic [8:0] CHROMA_OFS = 9'd128;

    localparam logic [0:0] REG_PAIRS = 1'b0;
    localparam logic [0:0] REG_LINES = 1'b1;

    typedef logic [7:0] chan_t;

    function automatic chan_t chan_clamp(input logic signed [SUM_W-1:0] s);
        logic [SUM_W-FRAC_W-1:0] q;
        chan_t                   res;
        q = s[SUM_W-1:FRAC_W];
        if (s < 0)
        begin
            res = 8'd0;
        end
        else if (q > (SUM_W-FRAC_W)'(255))
        begin
            res = 8'd255;
        end
        else
        begin
            res = q[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### rtl/ytb_convert.sv
// Color conversion of one macropixel: two luma samples and shared chroma
// to two clamped 8-bit BGR pixels, using Q2.14 fixed-point coefficients. Depends on ytb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ytb_convert (
    input  wire logic [7:0]    luma_first,
    input  wire logic [7:0]    chroma_blue,
    input  wire logic [7:0]    luma_second,
    input  wire logic [7:0]    chroma_red,
    output ytb_pkg::chan_t     blue_first,
    output ytb_pkg::chan_t     green_first,
    output ytb_pkg::chan_t     red_first,
    output ytb_pkg::chan_t     blue_second,
    output ytb_pkg::chan_t     green_second,
    output ytb_pkg::chan_t     red_second
);

    localparam int SW = ytb_pkg::SUM_W;

    logic signed [8:0]    du;
    logic signed [8:0]    dv;
    logic signed [SW-1:0] bterm;
    logic signed [SW-1:0] gterm;
    logic signed [SW-1:0] rterm;
    logic signed [SW-1:0] y1_term;
    logic signed [SW-1:0] y2_term;

    assign du = $signed({1'b0, chroma_blue} - ytb_pkg::CHROMA_OFS);
    assign dv = $signed({1'b0, chroma_red} - ytb_pkg::CHROMA_OFS);

    assign bterm = SW'(ytb_pkg::COEF_BU) * SW'(du);
    assign rterm = SW'(ytb_pkg::COEF_RV) * SW'(dv);
    assign gterm = -(SW'(ytb_pkg::COEF_GU) * SW'(du)) - (SW'(ytb_pkg::COEF_GV) * SW'(dv));

    assign y1_term = $signed({{(SW-8-ytb_pkg::FRAC_W){1'b0}}, luma_first,
                              {ytb_pkg::FRAC_W{1'b0}}});
    assign y2_term = $signed({{(SW-8-ytb_pkg::FRAC_W){1'b0}}, luma_second,
                              {ytb_pkg::FRAC_W{1'b0}}});

    assign blue_first   = ytb_pkg::chan_clamp(y1_term + bterm);
    assign green_first  = ytb_pkg::chan_clamp(y1_term + gterm);
    assign red_first    = ytb_pkg::chan_clamp(y1_term + rterm);
    assign blue_second  = ytb_pkg::chan_clamp(y2_term + bterm);
    assign green_second = ytb_pkg::chan_clamp(y2_term + gterm);
    assign red_second   = ytb_pkg::chan_clamp(y2_term + rterm);

endmodule

`default_nettype wire

### rtl/yuyv_to_bgr_bottom_up_core.sv
// YUYV 4:2:2 to BGR888 converter with bottom-up destination addressing.
// Top level; depends on ytb_pkg, ytb_convert and assert_macros.svh.
//
// Usage: one YUYV macropixel enters per beat on the in_valid/in_ready channel
// and one result beat leaves on out_valid/out_ready carrying two BGR pixels,
// the bottom-up destination pair index and a last-of-frame flag.
// An accepted beat passes through the input register and then the result register,
// whose valid flag drives out_valid.
// An input register holds the macropixel and its frame position, and the
// conversion and address multiply sit between it and the result register.
// Throughput is one beat per cycle while the receiver keeps out_ready high.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more beat; in_ready falls only when both are full.
// Reset clears both valid flags and the frame counters, and loads 640 pairs
// per line and 720 lines. The frame size registers sit on the APB port at
// byte addresses 0 and 4 and should be written only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module yuyv_to_bgr_bottom_up_core #(
    parameter int MAX_PAIRS_PER_LINE = 1024,
    parameter int MAX_LINES          = 1024
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  luma_first,
    input  wire logic [7:0]  chroma_blue,
    input  wire logic [7:0]  luma_second,
    input  wire logic [7:0]  chroma_red,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [7:0]       blue_first,
    output logic [7:0]       green_first,
    output logic [7:0]       red_first,
    output logic [7:0]       blue_second,
    output logic [7:0]       green_second,
    output logic [7:0]       red_second,
    output logic [19:0]      pair_address,
    output logic             frame_last
);

    localparam int CW    = ytb_pkg::CFG_W;
    localparam int COL_W = (MAX_PAIRS_PER_LINE > 1) ? $clog2(MAX_PAIRS_PER_LINE) : 1;
    localparam int ROW_W = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int XW    = (COL_W > CW) ? ((COL_W > ROW_W) ? COL_W : ROW_W)
                                        : ((ROW_W > CW) ? ROW_W : CW);
    localparam int PMAX  = (MAX_PAIRS_PER_LINE > ytb_pkg::CFG_MAX) ? ytb_pkg::CFG_MAX
                                                                   : MAX_PAIRS_PER_LINE;
    localparam int LMAX  = (MAX_LINES > ytb_pkg::CFG_MAX) ? ytb_pkg::CFG_MAX : MAX_LINES;
    localparam int AW    = ytb_pkg::ADDR_W;

    logic [CW-1:0]    pairs_cfg_reg;
    logic [CW-1:0]    lines_cfg_reg;
    logic [CW-1:0]    pairs_eff;
    logic [CW-1:0]    lines_eff;
    logic             cfg_write;

    logic [COL_W-1:0] col_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_reg;
    logic [ROW_W-1:0] row_next;
    logic [COL_W-1:0] col_cur;
    logic [ROW_W-1:0] row_cur;
    logic             col_last;
    logic             row_last;
    logic             in_fire;

    logic             s1_valid_reg;
    logic             s1_move;
    logic [7:0]       s1_luma_first_reg;
    logic [7:0]       s1_chroma_blue_reg;
    logic [7:0]       s1_luma_second_reg;
    logic [7:0]       s1_chroma_red_reg;
    logic [COL_W-1:0] s1_col_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic             s1_last_reg;

    logic [CW-1:0]    rows_below;
    logic [2*CW-1:0]  addr_prod;
    logic [2*CW-1:0]  addr_full;
    ytb_pkg::chan_t   cv_blue_first;
    ytb_pkg::chan_t   cv_green_first;
    ytb_pkg::chan_t   cv_red_first;
    ytb_pkg::chan_t   cv_blue_second;
    ytb_pkg::chan_t   cv_green_second;
    ytb_pkg::chan_t   cv_red_second;

    logic             out_valid_reg;
    logic             out_space;

    // Configuration port.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pairs_cfg_reg <= CW'(640);
            lines_cfg_reg <= CW'(720);
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                ytb_pkg::REG_PAIRS: pairs_cfg_reg <= pwdata[CW-1:0];
                ytb_pkg::REG_LINES: lines_cfg_reg <= pwdata[CW-1:0];
                default:            pairs_cfg_reg <= pairs_cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            ytb_pkg::REG_PAIRS: prdata = 32'(pairs_cfg_reg);
            ytb_pkg::REG_LINES: prdata = 32'(lines_cfg_reg);
            default:            prdata = 32'd0;
        endcase
    end

    // Effective frame size: zero acts as one, large values clip to the maximum.
    always_comb
    begin
        if (pairs_cfg_reg == '0)
            pairs_eff = CW'(1);
        else if (pairs_cfg_reg > CW'(PMAX))
            pairs_eff = CW'(PMAX);
        else
            pairs_eff = pairs_cfg_reg;

        if (lines_cfg_reg == '0)
            lines_eff = CW'(1);
        else if (lines_cfg_reg > CW'(LMAX))
            lines_eff = CW'(LMAX);
        else
            lines_eff = lines_cfg_reg;
    end

    // Handshake across the two registers.
    assign out_space = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_space;
    assign in_ready  = !s1_valid_reg || out_space;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;

    // Frame position of the incoming beat.
    always_comb
    begin
        col_cur  = (XW'(col_reg) >= XW'(pairs_eff)) ? '0 : col_reg;
        row_cur  = (XW'(row_reg) >= XW'(lines_eff)) ? '0 : row_reg;
        col_last = (XW'(col_cur) == XW'(pairs_eff) - XW'(1));
        row_last = (XW'(row_cur) == XW'(lines_eff) - XW'(1));
        if (col_last)
        begin
            col_next = '0;
            row_next = row_last ? '0 : row_cur + ROW_W'(1);
        end
        else
        begin
            col_next = col_cur + COL_W'(1);
            row_next = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (in_fire)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (in_ready)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_luma_first_reg  <= luma_first;
            s1_chroma_blue_reg <= chroma_blue;
            s1_luma_second_reg <= luma_second;
            s1_chroma_red_reg  <= chroma_red;
            s1_col_reg         <= col_cur;
            s1_row_reg         <= row_cur;
            s1_last_reg        <= col_last && row_last;
        end
    end

    ytb_convert u_convert (
        .luma_first   (s1_luma_first_reg),
        .chroma_blue  (s1_chroma_blue_reg),
        .luma_second  (s1_luma_second_reg),
        .chroma_red   (s1_chroma_red_reg),
        .blue_first   (cv_blue_first),
        .green_first  (cv_green_first),
        .red_first    (cv_red_first),
        .blue_second  (cv_blue_second),
        .green_second (cv_green_second),
        .red_second   (cv_red_second)
    );

    assign rows_below = lines_eff - CW'(1) - CW'(s1_row_reg);
    assign addr_prod  = (2*CW)'(rows_below) * (2*CW)'(pairs_eff);
    assign addr_full  = addr_prod + (2*CW)'(s1_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_space)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            blue_first   <= cv_blue_first;
            green_first  <= cv_green_first;
            red_first    <= cv_red_first;
            blue_second  <= cv_blue_second;
            green_second <= cv_green_second;
            red_second   <= cv_red_second;
            pair_address <= addr_full[AW-1:0];
            frame_last   <= s1_last_reg;
        end
    end

    `include "assert_macros.svh"

    `YTB_ASSERT_NXT(a_col_in_range, in_fire && !cfg_write, XW'(col_reg) < XW'(pairs_eff))
    `YTB_ASSERT_NXT(a_s1_holds, s1_valid_reg && !out_space, s1_valid_reg)
    `YTB_ASSERT_IMP(a_last_addr, out_valid_reg && frame_last,
                    pair_address == AW'(pairs_eff - CW'(1)))

endmodule

`default_nettype wire
